// ===== hdl/gwl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gwl_pkg;

    // Grid geometry.
    localparam int CELL_W   = 192;
    localparam int CELL_H   = 192;
    localparam int MAP_COLS = 32;
    localparam int MAP_ROWS = 32;

    // Fixed field widths of an item.
    localparam int COORD_W    = 13;
    localparam int CELL_IDX_W = 5;

    // Walk guard and derived widths.
    localparam int STEP_LIMIT = MAP_COLS + MAP_ROWS;
    localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
    localparam int CELL_MAX   = (CELL_W > CELL_H) ? CELL_W : CELL_H;
    localparam int DX_W       = COORD_W + 1;
    localparam int ADJ_W      = CELL_IDX_W + 1;
    localparam int LAT_W      = $clog2((2 ** CELL_IDX_W) * CELL_MAX + 2 ** COORD_W) + 1;
    localparam int POS_W      = $clog2(2 ** CELL_IDX_W + STEP_LIMIT) + 1;
    localparam int WALK_SPAN  = (2 ** CELL_IDX_W + STEP_LIMIT + 1) * CELL_MAX + 2 ** COORD_W;
    localparam int PROD_W     = $clog2(WALK_SPAN) + COORD_W + 2;

    // Wall store.
    localparam int GRID_DEPTH = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);

    // Queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic {
        F_IDLE,
        F_HOLD
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_WALK
    } back_state_t;

    // One classified item as it travels from front to back.
    typedef struct packed {
        logic                     kind;
        logic [CELL_IDX_W-1:0]    cell_x;
        logic [CELL_IDX_W-1:0]    cell_y;
        logic [CELL_IDX_W-1:0]    end_cell_x;
        logic [CELL_IDX_W-1:0]    end_cell_y;
        logic                     north_bit;
        logic                     west_bit;
        logic                     sx_nz;
        logic                     sx_pos;
        logic                     sy_nz;
        logic                     sy_pos;
        logic signed [PROD_W-1:0] lhs;
        logic signed [PROD_W-1:0] rhs;
        logic signed [PROD_W-1:0] inc_l;
        logic signed [PROD_W-1:0] inc_r;
    } gwl_job_t;

endpackage

`default_nettype wire

// ===== hdl/grid_wall_line_walk_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                         Payload
// -------   ---------  --------------------------------  ----------------------------------
// command   in         item taken when start && !busy    kind, start/end points and cells,
//                                                        north_bit, west_bit
// result    out        done high for one cycle per item  blocked
//
// With the back idle, an item passes the front registers and a queue entry before the back
// takes it; a query then steps n cells (n at most MAP_COLS + MAP_ROWS = 64, ending at the first
// wall). The walk is paced by the single read port of the wall store: each step issues one read,
// checked in the next cycle; the back pops no item while a query walks. After reset every cell
// of the wall store is cleared, one cell per cycle, while busy is high; busy is also high
// while the front holds an item and the two-entry queue is full.

module grid_wall_line_walk_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            kind,
    input  wire logic [gwl_pkg::COORD_W-1:0]     start_x,
    input  wire logic [gwl_pkg::COORD_W-1:0]     start_y,
    input  wire logic [gwl_pkg::CELL_IDX_W-1:0]  start_cell_x,
    input  wire logic [gwl_pkg::CELL_IDX_W-1:0]  start_cell_y,
    input  wire logic [gwl_pkg::COORD_W-1:0]     end_x,
    input  wire logic [gwl_pkg::COORD_W-1:0]     end_y,
    input  wire logic [gwl_pkg::CELL_IDX_W-1:0]  end_cell_x,
    input  wire logic [gwl_pkg::CELL_IDX_W-1:0]  end_cell_y,
    input  wire logic                            north_bit,
    input  wire logic                            west_bit,
    output logic                                 done,
    output logic                                 blocked
);
    import gwl_pkg::*;

    // The front takes an item, works out the walk direction, the distances to the first
    // grid lines and the two cross products, and hands a job to the queue.
    logic     q_full, q_empty, push, pop, clearing;
    gwl_job_t push_job, head;

    gwl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_cell_x (start_cell_x),
        .start_cell_y (start_cell_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .end_cell_x   (end_cell_x),
        .end_cell_y   (end_cell_y),
        .north_bit    (north_bit),
        .west_bit     (west_bit),
        .clearing     (clearing),
        .q_full       (q_full),
        .push         (push),
        .push_job     (push_job),
        .busy         (busy)
    );

    // The queue lets the front take the next item while the back is still walking.
    gwl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    // The back owns the wall store. Writes and queries are taken from the queue in order,
    // so a query always sees every write accepted before it. During a walk the cross
    // products are updated by adding or subtracting a precomputed step, and the wall read issued for one
    // step is checked in the cycle that issues the next.
    gwl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .blocked  (blocked)
    );

endmodule

`default_nettype wire

// ===== hdl/gwl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gwl_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            kind,
    input  wire logic [gwl_pkg::COORD_W-1:0]     start_x,
    input  wire logic [gwl_pkg::COORD_W-1:0]     start_y,
    input  wire logic [gwl_pkg::CELL_IDX_W-1:0]  start_cell_x,
    input  wire logic [gwl_pkg::CELL_IDX_W-1:0]  start_cell_y,
    input  wire logic [gwl_pkg::COORD_W-1:0]     end_x,
    input  wire logic [gwl_pkg::COORD_W-1:0]     end_y,
    input  wire logic [gwl_pkg::CELL_IDX_W-1:0]  end_cell_x,
    input  wire logic [gwl_pkg::CELL_IDX_W-1:0]  end_cell_y,
    input  wire logic                            north_bit,
    input  wire logic                            west_bit,
    input  wire logic                            clearing,
    input  wire logic                            q_full,
    output logic                                 push,
    output gwl_pkg::gwl_job_t                    push_job,
    output logic                                 busy
);
    import gwl_pkg::*;

    front_state_t state_reg, state_next;
    logic         accept;

    logic                     kind_reg;
    logic [CELL_IDX_W-1:0]    cell_x_reg, cell_y_reg, end_cell_x_reg, end_cell_y_reg;
    logic                     north_reg, west_reg;
    logic                     sx_nz_reg, sx_pos_reg, sy_nz_reg, sy_pos_reg;
    logic signed [DX_W-1:0]   dx_reg, dy_reg;
    logic signed [LAT_W-1:0]  lat_dx_reg, lat_dy_reg;
    logic signed [PROD_W-1:0] inc_l_reg, inc_r_reg;

    logic                     sx_pos_in, sy_pos_in;
    logic [ADJ_W-1:0]         adj_x, adj_y;
    logic signed [DX_W-1:0]   dx_in, dy_in;
    logic signed [LAT_W-1:0]  lat_dx_in, lat_dy_in;

    // Direction and distances to the first grid lines the walk will meet.
    always_comb
    begin
        sx_pos_in = end_cell_x > start_cell_x;
        sy_pos_in = end_cell_y > start_cell_y;
        adj_x     = ADJ_W'(start_cell_x) + ADJ_W'(sx_pos_in);
        adj_y     = ADJ_W'(start_cell_y) + ADJ_W'(sy_pos_in);
        dx_in     = DX_W'(end_x) - DX_W'(start_x);
        dy_in     = DX_W'(end_y) - DX_W'(start_y);
        lat_dx_in = LAT_W'(adj_x) * LAT_W'(CELL_W) - LAT_W'(start_x);
        lat_dy_in = LAT_W'(adj_y) * LAT_W'(CELL_H) - LAT_W'(start_y);
    end

    always_comb
    begin
        push       = (state_reg == F_HOLD) && !q_full;
        busy       = clearing || ((state_reg == F_HOLD) && q_full);
        accept     = start && !busy;
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_HOLD;
            end
            F_HOLD:
            begin
                if (!accept && push)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg       <= kind;
            cell_x_reg     <= start_cell_x;
            cell_y_reg     <= start_cell_y;
            end_cell_x_reg <= end_cell_x;
            end_cell_y_reg <= end_cell_y;
            north_reg      <= north_bit;
            west_reg       <= west_bit;
            sx_nz_reg      <= end_cell_x != start_cell_x;
            sx_pos_reg     <= sx_pos_in;
            sy_nz_reg      <= end_cell_y != start_cell_y;
            sy_pos_reg     <= sy_pos_in;
            dx_reg         <= dx_in;
            dy_reg         <= dy_in;
            lat_dx_reg     <= lat_dx_in;
            lat_dy_reg     <= lat_dy_in;
            inc_l_reg      <= PROD_W'(dx_in) * PROD_W'(CELL_H);
            inc_r_reg      <= PROD_W'(dy_in) * PROD_W'(CELL_W);
        end
    end

    // The two cross products are formed here and registered by the queue.
    always_comb
    begin
        push_job.kind       = kind_reg;
        push_job.cell_x     = cell_x_reg;
        push_job.cell_y     = cell_y_reg;
        push_job.end_cell_x = end_cell_x_reg;
        push_job.end_cell_y = end_cell_y_reg;
        push_job.north_bit  = north_reg;
        push_job.west_bit   = west_reg;
        push_job.sx_nz      = sx_nz_reg;
        push_job.sx_pos     = sx_pos_reg;
        push_job.sy_nz      = sy_nz_reg;
        push_job.sy_pos     = sy_pos_reg;
        push_job.lhs        = PROD_W'(lat_dy_reg) * PROD_W'(dx_reg);
        push_job.rhs        = PROD_W'(dy_reg) * PROD_W'(lat_dx_reg);
        push_job.inc_l      = inc_l_reg;
        push_job.inc_r      = inc_r_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/gwl_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gwl_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire gwl_pkg::gwl_job_t  push_job,
    output logic                    full,
    input  wire logic               pop,
    output gwl_pkg::gwl_job_t       head,
    output logic                    empty
);
    import gwl_pkg::*;

    gwl_job_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    always_comb
    begin
        full  = count_reg == (QPTR_W + 1)'(QDEPTH);
        empty = count_reg == '0;
        head  = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ===== hdl/gwl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gwl_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire gwl_pkg::gwl_job_t  head,
    output logic                    pop,
    output logic                    clearing,
    output logic                    done,
    output logic                    blocked
);
    import gwl_pkg::*;

    back_state_t state_reg, state_next;

    logic [1:0] grid_mem [GRID_DEPTH];
    logic [1:0] rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [1:0]         mem_wdata;

    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;

    logic signed [POS_W-1:0]  gx_reg, gx_next, gy_reg, gy_next;
    logic [CELL_IDX_W-1:0]    fx_reg, fx_next, fy_reg, fy_next;
    logic                     sx_nz_reg, sx_nz_next, sx_pos_reg, sx_pos_next;
    logic                     sy_nz_reg, sy_nz_next, sy_pos_reg, sy_pos_next;
    logic signed [PROD_W-1:0] lhs_reg, lhs_next, rhs_reg, rhs_next;
    logic signed [PROD_W-1:0] inc_l_reg, inc_l_next, inc_r_reg, inc_r_next;
    logic [STEP_W-1:0]        steps_reg, steps_next;
    logic                     pend_reg, pend_next, pend_north_reg, pend_north_next;
    logic                     done_reg, done_next, blocked_reg, blocked_next;

    logic                     at_end, go_on, hit, vertical, chk_in_grid, head_in_grid;
    logic signed [POS_W-1:0]  chk_x, chk_y;
    logic [ADDR_W-1:0]        chk_addr, head_addr;

    // Wall store, one access per port per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= grid_mem[mem_raddr];
    end

    // Which grid line the next step crosses, and the cell whose wall guards it.
    always_comb
    begin
        priority if (!sx_nz_reg)
            vertical = 1'b1;
        else if (!sy_nz_reg)
            vertical = 1'b0;
        else if (sx_pos_reg && sy_pos_reg)
            vertical = lhs_reg < rhs_reg;
        else if (sx_pos_reg)
            vertical = lhs_reg > rhs_reg;
        else if (sy_pos_reg)
            vertical = lhs_reg >= rhs_reg;
        else
            vertical = lhs_reg < rhs_reg;

        chk_x = (!vertical && sx_pos_reg) ? gx_reg + POS_W'(1) : gx_reg;
        chk_y = (vertical && sy_pos_reg) ? gy_reg + POS_W'(1) : gy_reg;
        chk_in_grid = !chk_x[POS_W-1] && !chk_y[POS_W-1]
                      && (int'(chk_x) < MAP_COLS) && (int'(chk_y) < MAP_ROWS);
        chk_addr  = ADDR_W'(int'(chk_x) * MAP_ROWS + int'(chk_y));

        head_in_grid = (int'(head.cell_x) < MAP_COLS) && (int'(head.cell_y) < MAP_ROWS);
        head_addr    = ADDR_W'(int'(head.cell_x) * MAP_ROWS + int'(head.cell_y));

        at_end = (gx_reg == POS_W'(fx_reg)) && (gy_reg == POS_W'(fy_reg));
        go_on  = !at_end && (steps_reg < STEP_W'(STEP_LIMIT));
        hit    = pend_reg && (pend_north_reg ? rd_data_reg[0] : rd_data_reg[1]);
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        sx_nz_next      = sx_nz_reg;
        sx_pos_next     = sx_pos_reg;
        sy_nz_next      = sy_nz_reg;
        sy_pos_next     = sy_pos_reg;
        lhs_next        = lhs_reg;
        rhs_next        = rhs_reg;
        inc_l_next      = inc_l_reg;
        inc_r_next      = inc_r_reg;
        steps_next      = steps_reg;
        pend_next       = 1'b0;
        pend_north_next = pend_north_reg;
        done_next       = 1'b0;
        blocked_next    = 1'b0;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = clr_cnt_reg;
        mem_wdata       = 2'b00;
        mem_raddr       = chk_addr;

        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(GRID_DEPTH - 1))
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (head.kind == KIND_WRITE)
                    begin
                        mem_we    = head_in_grid;
                        mem_waddr = head_addr;
                        mem_wdata = {head.west_bit, head.north_bit};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        gx_next     = POS_W'(head.cell_x);
                        gy_next     = POS_W'(head.cell_y);
                        fx_next     = head.end_cell_x;
                        fy_next     = head.end_cell_y;
                        sx_nz_next  = head.sx_nz;
                        sx_pos_next = head.sx_pos;
                        sy_nz_next  = head.sy_nz;
                        sy_pos_next = head.sy_pos;
                        lhs_next    = head.lhs;
                        rhs_next    = head.rhs;
                        inc_l_next  = head.inc_l;
                        inc_r_next  = head.inc_r;
                        steps_next  = '0;
                        state_next  = B_WALK;
                    end
                end
            end
            B_WALK:
            begin
                if (hit)
                begin
                    done_next    = 1'b1;
                    blocked_next = 1'b1;
                    state_next   = B_IDLE;
                end
                else if (go_on)
                begin
                    steps_next      = steps_reg + STEP_W'(1);
                    pend_next       = chk_in_grid;
                    pend_north_next = vertical;
                    if (vertical)
                    begin
                        gy_next  = sy_pos_reg ? gy_reg + POS_W'(1) : gy_reg - POS_W'(1);
                        lhs_next = sy_pos_reg ? lhs_reg + inc_l_reg : lhs_reg - inc_l_reg;
                    end
                    else
                    begin
                        gx_next  = sx_pos_reg ? gx_reg + POS_W'(1) : gx_reg - POS_W'(1);
                        rhs_next = sx_pos_reg ? rhs_reg + inc_r_reg : rhs_reg - inc_r_reg;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            blocked_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            blocked_reg <= blocked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gx_reg         <= gx_next;
        gy_reg         <= gy_next;
        fx_reg         <= fx_next;
        fy_reg         <= fy_next;
        sx_nz_reg      <= sx_nz_next;
        sx_pos_reg     <= sx_pos_next;
        sy_nz_reg      <= sy_nz_next;
        sy_pos_reg     <= sy_pos_next;
        lhs_reg        <= lhs_next;
        rhs_reg        <= rhs_next;
        inc_l_reg      <= inc_l_next;
        inc_r_reg      <= inc_r_next;
        steps_reg      <= steps_next;
        pend_north_reg <= pend_north_next;
    end

    assign clearing = state_reg == B_CLEAR;
    assign done     = done_reg;
    assign blocked  = blocked_reg;

endmodule

`default_nettype wire
